FILE: design/tcp_segment_header_builder_macros.svh
// Assertion macros shared by the TCP segment header builder.
// Uses the clk_i / rst_ni names of the module that includes it.
`ifndef TCP_SEGMENT_HEADER_BUILDER_MACROS_SVH
`define TCP_SEGMENT_HEADER_BUILDER_MACROS_SVH

// Property checked on every rising edge outside reset
`define TSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tcp header builder check failed");

// Condition in one cycle implies a consequence in the next
`define TSH_ASSERT_NEXT(lbl, ante, cons) \
  `TSH_ASSERT(lbl, (ante) |=> (cons))

`endif

FILE: design/tsh_pkg.sv
// Package for the TCP segment header builder: types, header constants,
// and the ones-complement fold helper. No dependencies.
package tsh_pkg;

  localparam int unsigned HdrWords = 27;

  localparam logic [4:0]  LastIdx       = 5'(HdrWords - 1);
  localparam logic [10:0] HdrBytes      = 11'd54;
  localparam logic [10:0] IpTcpHdrBytes = 11'd40;
  localparam logic [10:0] TcpHdrBytes   = 11'd20;
  localparam logic [10:0] MaxPayload    = 11'd1460;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] IpVerIhl      = 16'h4500;
  localparam logic [15:0] IpId          = 16'd31143;
  localparam logic [15:0] IpTtlProto    = {8'd64, 8'd6};
  localparam logic [15:0] ProtoTcp      = 16'd6;
  localparam logic [15:0] TcpWindow     = 16'hffff;
  localparam logic [31:0] SynSeq        = 32'hffffffff;

  localparam logic [15:0] TcpOffset = 16'h5000;
  localparam logic [15:0] FlagFin   = 16'h0001;
  localparam logic [15:0] FlagSyn   = 16'h0002;
  localparam logic [15:0] FlagPsh   = 16'h0008;
  localparam logic [15:0] FlagAck   = 16'h0010;

  // Config register indexes
  localparam logic [3:0] RegDestMac    = 4'd0;
  localparam logic [3:0] RegSourceMac  = 4'd1;
  localparam logic [3:0] RegSourceIp   = 4'd2;
  localparam logic [3:0] RegDestIp     = 4'd3;
  localparam logic [3:0] RegSourcePort = 4'd4;
  localparam logic [3:0] RegDestPort   = 4'd5;
  localparam logic [3:0] RegPayloadLen = 4'd6;
  localparam logic [3:0] RegPayloadSum = 4'd7;

  typedef enum logic [1:0] {
    KindSyn    = 2'd0,
    KindAck    = 2'd1,
    KindFinAck = 2'd2,
    KindPshAck = 2'd3
  } req_kind_e;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [10:0] payload_len;
    logic [15:0] payload_sum;
  } cfg_t;

  typedef logic [HdrWords-1:0][15:0] hdr_t;

  // Serializer status toward the input stage
  typedef struct packed {
    logic load_ready;
    logic busy;
  } ser_status_t;

  // Fold a sum of up to sixteen words with end-around carry, then invert
  function automatic logic [15:0] fold_invert(input logic [19:0] sum);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    return ~s2;
  endfunction

  function automatic logic [19:0] ext20(input logic [15:0] w);
    return {4'd0, w};
  endfunction

endpackage

FILE: design/tsh_cfg_regs.sv
// Configuration register file of the TCP segment header builder.
// Depends on tsh_pkg for register indexes and cfg_t.
module tsh_cfg_regs import tsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [3:0]  wr_index_i,
  input  logic [47:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegDestMac:    cfg_d.dest_mac    = wr_data_i;
        RegSourceMac:  cfg_d.source_mac  = wr_data_i;
        RegSourceIp:   cfg_d.source_ip   = wr_data_i[31:0];
        RegDestIp:     cfg_d.dest_ip     = wr_data_i[31:0];
        RegSourcePort: cfg_d.source_port = wr_data_i[15:0];
        RegDestPort:   cfg_d.dest_port   = wr_data_i[15:0];
        RegPayloadLen: cfg_d.payload_len = wr_data_i[10:0];
        RegPayloadSum: cfg_d.payload_sum = wr_data_i[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/tsh_header_calc.sv
// Builds the 27 header words and both checksums for one request.
// Pure combinational logic; depends on tsh_pkg.
module tsh_header_calc import tsh_pkg::*; (
  input  cfg_t        cfg_i,
  input  req_kind_e   kind_i,
  input  logic [31:0] recv_seq_i,
  input  logic [31:0] recv_ack_i,
  output hdr_t        words_o,
  output logic [10:0] frame_bytes_o
);

  logic [10:0] plen;
  logic [31:0] seq, ack;
  logic [15:0] flags;
  logic [19:0] ip_sum, tcp_sum;
  logic [15:0] extra_sum;
  hdr_t        w;

  // Sequence, acknowledgment and flags per request kind
  always_comb begin
    plen      = '0;
    extra_sum = '0;
    seq       = recv_ack_i;
    ack       = recv_seq_i + 32'd1;
    flags     = FlagAck;
    case (kind_i)
      KindSyn: begin
        seq   = SynSeq;
        ack   = '0;
        flags = FlagSyn;
      end
      KindFinAck: flags = FlagAck | FlagFin;
      KindPshAck: begin
        flags     = FlagAck | FlagPsh;
        plen      = (cfg_i.payload_len > MaxPayload) ? MaxPayload : cfg_i.payload_len;
        extra_sum = cfg_i.payload_sum;
      end
      default: flags = FlagAck;
    endcase
  end

  // Header words in network order, checksums filled in below
  always_comb begin
    w     = '0;
    w[0]  = cfg_i.dest_mac[47:32];
    w[1]  = cfg_i.dest_mac[31:16];
    w[2]  = cfg_i.dest_mac[15:0];
    w[3]  = cfg_i.source_mac[47:32];
    w[4]  = cfg_i.source_mac[31:16];
    w[5]  = cfg_i.source_mac[15:0];
    w[6]  = EtherTypeIpv4;
    w[7]  = IpVerIhl;
    w[8]  = {5'd0, IpTcpHdrBytes + plen};
    w[9]  = IpId;
    w[10] = '0;
    w[11] = IpTtlProto;
    w[13] = cfg_i.source_ip[31:16];
    w[14] = cfg_i.source_ip[15:0];
    w[15] = cfg_i.dest_ip[31:16];
    w[16] = cfg_i.dest_ip[15:0];
    w[17] = cfg_i.source_port;
    w[18] = cfg_i.dest_port;
    w[19] = seq[31:16];
    w[20] = seq[15:0];
    w[21] = ack[31:16];
    w[22] = ack[15:0];
    w[23] = TcpOffset | flags;
    w[24] = TcpWindow;
    w[26] = '0;

    // IPv4 header sum, checksum word itself taken as zero
    ip_sum = ((ext20(w[7]) + ext20(w[8])) + (ext20(w[9]) + ext20(w[11])))
           + ((ext20(w[13]) + ext20(w[14])) + (ext20(w[15]) + ext20(w[16])));

    // Pseudo-header, TCP header and payload sum
    tcp_sum = ((ext20(w[13]) + ext20(w[14])) + (ext20(w[15]) + ext20(w[16])))
            + ((ext20(ProtoTcp) + ext20({5'd0, TcpHdrBytes + plen}))
            +  (ext20(w[17]) + ext20(w[18])))
            + ((ext20(w[19]) + ext20(w[20])) + (ext20(w[21]) + ext20(w[22])))
            + ((ext20(w[23]) + ext20(w[24])) + ext20(extra_sum));

    w[12] = fold_invert(ip_sum);
    w[25] = fold_invert(tcp_sum);
  end

  assign words_o       = w;
  assign frame_bytes_o = HdrBytes + plen;

endmodule

FILE: design/tsh_serializer.sv
// Frame register and word serializer: holds one built header and shifts
// it out one word per beat. Depends on tsh_pkg.
module tsh_serializer import tsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  hdr_t        words_i,
  input  logic [10:0] frame_bytes_i,
  output ser_status_t status_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] word_o,
  output logic [4:0]  index_o,
  output logic        last_o,
  output logic [10:0] frame_bytes_o
);

  logic        busy_d, busy_q;
  logic [4:0]  idx_d, idx_q;
  hdr_t        frame_d, frame_q;
  logic [10:0] bytes_d, bytes_q;
  logic        beat, last;

  assign beat = busy_q && ready_i;
  assign last = (idx_q == LastIdx);

  // Free when empty or when the last word leaves this cycle
  assign status_o.load_ready = !busy_q || (ready_i && last);
  assign status_o.busy       = busy_q;

  // Next state of the counter and the frame shift line
  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    bytes_d = bytes_q;
    if (beat) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d   = idx_q + 5'd1;
        frame_d = {16'd0, frame_q[HdrWords-1:1]};
      end
    end
    if (load_i) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      frame_d = words_i;
      bytes_d = frame_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    bytes_q <= bytes_d;
  end

  assign valid_o       = busy_q;
  assign word_o        = frame_q[0];
  assign index_o       = idx_q;
  assign last_o        = last;
  assign frame_bytes_o = bytes_q;

endmodule

FILE: design/tcp_segment_header_builder.sv
// A taken request waits in the input register, then loads into the frame register;
// the 27 words then follow one per beat, tlast on word 26.
// The single output word port paces frames; a new one loads as the last leaves.
// A request may wait in the input register while the previous frame drains.
// Reset: pipeline empties at once, all config registers read 0; no sweep.
`include "tcp_segment_header_builder_macros.svh"

module tcp_segment_header_builder import tsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // recv_seq[31:0], recv_ack[63:32]
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  // Header word stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // header_word[15:0], word_index[20:16],
                                       // frame_bytes[31:21]
  output logic        m_axis_tlast_o   // last_word
);

  cfg_t        cfg;
  ser_status_t ser_status;
  hdr_t        words;
  logic [10:0] frame_bytes;
  logic        in_accept, load;

  logic        in_valid_d, in_valid_q;
  req_kind_e   kind_d, kind_q;
  logic [31:0] seq_d, seq_q, ack_d, ack_q;

  logic [15:0] out_word;
  logic [4:0]  out_index;
  logic [10:0] out_bytes;

  assign cfg_ready_o = 1'b1;

  tsh_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register: takes a request whenever empty or moving on
  assign load            = in_valid_q && ser_status.load_ready;
  assign s_axis_tready_o = !in_valid_q || load;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    kind_d     = kind_q;
    seq_d      = seq_q;
    ack_d      = ack_q;
    if (load) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
      kind_d     = req_kind_e'(s_axis_tuser_i);
      seq_d      = s_axis_tdata_i[31:0];
      ack_d      = s_axis_tdata_i[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    seq_q  <= seq_d;
    ack_q  <= ack_d;
  end

  tsh_header_calc u_calc (
    .cfg_i         (cfg),
    .kind_i        (kind_q),
    .recv_seq_i    (seq_q),
    .recv_ack_i    (ack_q),
    .words_o       (words),
    .frame_bytes_o (frame_bytes)
  );

  tsh_serializer u_ser (
    .clk_i,
    .rst_ni,
    .load_i        (load),
    .words_i       (words),
    .frame_bytes_i (frame_bytes),
    .status_o      (ser_status),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .word_o        (out_word),
    .index_o       (out_index),
    .last_o        (m_axis_tlast_o),
    .frame_bytes_o (out_bytes)
  );

  assign m_axis_tdata_o = {out_bytes, out_index, out_word};

  // A frame in progress keeps going after a word that is not the last
  `TSH_ASSERT_NEXT(a_run_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o)
  // Word index steps by one on each taken word within a frame
  `TSH_ASSERT_NEXT(a_index_steps, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, out_index == $past(out_index) + 5'd1)
  // A waiting request reaches an idle serializer on the next edge
  `TSH_ASSERT_NEXT(a_pending_loads, in_valid_q && !ser_status.busy, m_axis_tvalid_o && out_index == '0)
  // An accepted request is held in the input register
  `TSH_ASSERT_NEXT(a_accept_held, in_accept, in_valid_q)

endmodule
